FILE: hw/rtl/atrp_pkg.sv
// ----------------------------------------------------------------------------
// atrp_pkg: shared types and constants for the tilt angle pipeline
// Fixed internal widths, the cordic angle table and the side-band struct.
// ----------------------------------------------------------------------------
package atrp_pkg;

   localparam int RAD_WIDTH    = 62;  // scaled magnitude fed to the root
   localparam int ROOT_WIDTH   = 31;  // integer square root
   localparam int VEC_WIDTH    = 34;  // cordic x and y, signed
   localparam int ANG_WIDTH    = 33;  // cordic angle accumulator, signed, q24 degrees
   localparam int TAB_FRAC     = 24;
   localparam int CORDIC_STEPS = 28;
   localparam int ANGLE_WIDTH  = 16;
   localparam int FRONT_STAGES = 2;
   localparam int LANE_DEPTH   = FRONT_STAGES + ROOT_WIDTH + CORDIC_STEPS + 1;

   // atan(2^-i) in degrees, 24 fraction bits
   localparam int unsigned ATAN_TAB [CORDIC_STEPS] = '{
      32'd754974720, 32'd445687601, 32'd235489088, 32'd119537938,
      32'd60000934,  32'd30029716,  32'd15018522,  32'd7509719,
      32'd3754917,   32'd1877465,   32'd938733,    32'd469366,
      32'd234683,    32'd117341,    32'd58670,     32'd29335,
      32'd14667,     32'd7333,      32'd3666,      32'd1833,
      32'd916,       32'd458,       32'd229,       32'd114,
      32'd57,        32'd28,        32'd14,        32'd7
   };

   typedef struct packed {
      logic neg;       // numerator below zero
      logic num_zero;  // numerator is zero
      logic mag_zero;  // magnitude is zero
   } side_type;

endpackage

FILE: hw/rtl/atrp_sqrt_cell.sv
// ----------------------------------------------------------------------------
// atrp_sqrt_cell: one result bit of the pipelined integer square root
// Tries bit BIT of the root against the running remainder.
// ----------------------------------------------------------------------------
module atrp_sqrt_cell #(
   parameter int BIT = 0
) (
   input  logic                                clock,
   input  logic                                en,
   input  logic [atrp_pkg::RAD_WIDTH-1:0]      rem_i,
   input  logic [atrp_pkg::ROOT_WIDTH-1:0]     root_i,
   input  logic [atrp_pkg::ROOT_WIDTH-1:0]     b_i,
   input  atrp_pkg::side_type                  side_i,
   output logic [atrp_pkg::RAD_WIDTH-1:0]      rem_o,
   output logic [atrp_pkg::ROOT_WIDTH-1:0]     root_o,
   output logic [atrp_pkg::ROOT_WIDTH-1:0]     b_o,
   output atrp_pkg::side_type                  side_o
);
   import atrp_pkg::*;

   logic [RAD_WIDTH-1:0]  need;
   logic [RAD_WIDTH-1:0]  rem_in, rem_ff;
   logic [ROOT_WIDTH-1:0] root_in, root_ff, b_ff;
   side_type              side_ff;

   // (2r + 2^j) * 2^j is the growth of the square when bit j is set
   assign need = (RAD_WIDTH'(root_i) << (BIT + 1)) + (RAD_WIDTH'(1) << (2 * BIT));

   always_comb begin
      rem_in  = rem_i;
      root_in = root_i;
      if (rem_i >= need) begin
         rem_in  = rem_i - need;
         root_in = root_i | (ROOT_WIDTH'(1) << BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         b_ff    <= b_i;
         side_ff <= side_i;
      end
   end

   assign rem_o  = rem_ff;
   assign root_o = root_ff;
   assign b_o    = b_ff;
   assign side_o = side_ff;

endmodule

FILE: hw/rtl/atrp_cordic_cell.sv
// ----------------------------------------------------------------------------
// atrp_cordic_cell: one vectoring micro-rotation
// Rotates (x, y) towards the x axis by atan(2^-STEP) and sums the angle.
// ----------------------------------------------------------------------------
module atrp_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                                   clock,
   input  logic                                   en,
   input  logic signed [atrp_pkg::VEC_WIDTH-1:0]  x_i,
   input  logic signed [atrp_pkg::VEC_WIDTH-1:0]  y_i,
   input  logic signed [atrp_pkg::ANG_WIDTH-1:0]  ang_i,
   input  atrp_pkg::side_type                     side_i,
   output logic signed [atrp_pkg::VEC_WIDTH-1:0]  x_o,
   output logic signed [atrp_pkg::VEC_WIDTH-1:0]  y_o,
   output logic signed [atrp_pkg::ANG_WIDTH-1:0]  ang_o,
   output atrp_pkg::side_type                     side_o
);
   import atrp_pkg::*;

   localparam logic signed [ANG_WIDTH-1:0] StepAngle = ANG_WIDTH'(ATAN_TAB[STEP]);

   logic signed [VEC_WIDTH-1:0] x_in, y_in, x_ff, y_ff;
   logic signed [ANG_WIDTH-1:0] ang_in, ang_ff;
   side_type                    side_ff;

   always_comb begin
      if (y_i >= 0) begin
         x_in   = x_i + (y_i >>> STEP);
         y_in   = y_i - (x_i >>> STEP);
         ang_in = ang_i + StepAngle;
      end else begin
         x_in   = x_i - (y_i >>> STEP);
         y_in   = y_i + (x_i >>> STEP);
         ang_in = ang_i - StepAngle;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         ang_ff  <= ang_in;
         side_ff <= side_i;
      end
   end

   assign x_o    = x_ff;
   assign y_o    = y_ff;
   assign ang_o  = ang_ff;
   assign side_o = side_ff;

endmodule

FILE: hw/rtl/atrp_lane.sv
// ----------------------------------------------------------------------------
// atrp_lane: one arctangent lane
// atan(num / sqrt(p^2 + q^2)) through squares, a root chain, a cordic chain
// and a rounding stage.
// ----------------------------------------------------------------------------
module atrp_lane #(
   parameter int SAMPLE_WIDTH    = 16,
   parameter int ANGLE_FRAC_BITS = 8
) (
   input  logic                                     clock,
   input  logic                                     en,
   input  logic signed [SAMPLE_WIDTH:0]             num_i,
   input  logic signed [SAMPLE_WIDTH-1:0]           p_i,
   input  logic signed [SAMPLE_WIDTH-1:0]           q_i,
   output logic        [atrp_pkg::ANGLE_WIDTH-1:0]  angle_o,
   output logic                                     undef_o
);
   import atrp_pkg::*;

   localparam int K      = 31 - SAMPLE_WIDTH;
   localparam int SW2    = 2 * SAMPLE_WIDTH;
   localparam int Shift  = TAB_FRAC - ANGLE_FRAC_BITS;
   localparam logic signed [VEC_WIDTH-1:0] Full = VEC_WIDTH'(90) <<< ANGLE_FRAC_BITS;
   localparam logic signed [VEC_WIDTH-1:0] Half = VEC_WIDTH'(1) <<< (Shift - 1);

   // front: squares, then sum and scaling
   logic [SW2-1:0]          sq_p_ff, sq_q_ff;
   logic [SAMPLE_WIDTH:0]   nabs_in;
   logic [SAMPLE_WIDTH-1:0] nabs_ff;
   side_type                s0_side_in, s0_side_ff, s1_side_in, s1_side_ff;
   logic [SW2-1:0]          mag;
   logic [RAD_WIDTH-1:0]    rad_ff;
   logic [ROOT_WIDTH-1:0]   b_ff;

   assign nabs_in             = num_i[SAMPLE_WIDTH] ? -$unsigned(num_i) : $unsigned(num_i);
   assign s0_side_in.neg      = num_i[SAMPLE_WIDTH];
   assign s0_side_in.num_zero = (num_i == '0);
   assign s0_side_in.mag_zero = 1'b0;

   // operands widened first so the square keeps all its bits
   always_ff @(posedge clock) begin
      if (en) begin
         sq_p_ff    <= $unsigned(SW2'(p_i) * SW2'(p_i));
         sq_q_ff    <= $unsigned(SW2'(q_i) * SW2'(q_i));
         nabs_ff    <= nabs_in[SAMPLE_WIDTH-1:0];
         s0_side_ff <= s0_side_in;
      end
   end

   assign mag = sq_p_ff + sq_q_ff;

   always_comb begin
      s1_side_in          = s0_side_ff;
      s1_side_in.mag_zero = (mag == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff     <= RAD_WIDTH'(mag) << (2 * K);
         b_ff       <= ROOT_WIDTH'(nabs_ff) << K;
         s1_side_ff <= s1_side_in;
      end
   end

   // root chain, most significant bit first
   logic [RAD_WIDTH-1:0]  rem_c  [ROOT_WIDTH+1];
   logic [ROOT_WIDTH-1:0] root_c [ROOT_WIDTH+1];
   logic [ROOT_WIDTH-1:0] b_c    [ROOT_WIDTH+1];
   side_type              rs_c   [ROOT_WIDTH+1];

   assign rem_c[0]  = rad_ff;
   assign root_c[0] = '0;
   assign b_c[0]    = b_ff;
   assign rs_c[0]   = s1_side_ff;

   for (genvar g = 0; g < ROOT_WIDTH; g++) begin : g_root
      atrp_sqrt_cell #(.BIT(ROOT_WIDTH - 1 - g)) u_cell (
         .clock  (clock),
         .en     (en),
         .rem_i  (rem_c[g]),
         .root_i (root_c[g]),
         .b_i    (b_c[g]),
         .side_i (rs_c[g]),
         .rem_o  (rem_c[g+1]),
         .root_o (root_c[g+1]),
         .b_o    (b_c[g+1]),
         .side_o (rs_c[g+1])
      );
   end

   // cordic chain
   logic signed [VEC_WIDTH-1:0] x_c   [CORDIC_STEPS+1];
   logic signed [VEC_WIDTH-1:0] y_c   [CORDIC_STEPS+1];
   logic signed [ANG_WIDTH-1:0] ang_c [CORDIC_STEPS+1];
   side_type                    cs_c  [CORDIC_STEPS+1];

   assign x_c[0]   = $signed(VEC_WIDTH'(root_c[ROOT_WIDTH]));
   assign y_c[0]   = $signed(VEC_WIDTH'(b_c[ROOT_WIDTH]));
   assign ang_c[0] = '0;
   assign cs_c[0]  = rs_c[ROOT_WIDTH];

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
      atrp_cordic_cell #(.STEP(g)) u_cell (
         .clock  (clock),
         .en     (en),
         .x_i    (x_c[g]),
         .y_i    (y_c[g]),
         .ang_i  (ang_c[g]),
         .side_i (cs_c[g]),
         .x_o    (x_c[g+1]),
         .y_o    (y_c[g+1]),
         .ang_o  (ang_c[g+1]),
         .side_o (cs_c[g+1])
      );
   end

   // round half up, clamp to 0..90 degrees, then apply the sign
   logic signed [VEC_WIDTH-1:0] rnd, mag_r, clamped, signed_r;
   side_type                    fin;
   logic [ANGLE_WIDTH-1:0]      angle_in, angle_ff;
   logic                        undef_in, undef_ff;

   assign fin   = cs_c[CORDIC_STEPS];
   assign rnd   = VEC_WIDTH'(ang_c[CORDIC_STEPS]) + Half;
   assign mag_r = rnd >>> Shift;

   always_comb begin
      clamped = mag_r;
      if (mag_r < 0) begin
         clamped = '0;
      end else if (mag_r > Full) begin
         clamped = Full;
      end
      if (fin.mag_zero) begin
         clamped = fin.num_zero ? '0 : Full;
      end
      signed_r = fin.neg ? -clamped : clamped;
      angle_in = signed_r[ANGLE_WIDTH-1:0];
      undef_in = fin.mag_zero & fin.num_zero;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= angle_in;
         undef_ff <= undef_in;
      end
   end

   assign angle_o = angle_ff;
   assign undef_o = undef_ff;

endmodule

FILE: hw/rtl/accel_tilt_roll_pitch.sv
// ----------------------------------------------------------------------------
// accel_tilt_roll_pitch: roll and pitch from a three-axis accelerometer sample
// Two arctangent lanes side by side behind one beat of input, one output
// register in front of the result channel.
// ----------------------------------------------------------------------------
// Takes one sample per clock while not stalled, returns one result beat per
// sample, in order. A sample passes a squaring and a scaling register, 31
// cells of the bit-per-cell square root, 28 cordic cells, one rounding
// stage and the output register. The whole chain moves together; it stops
// only when a finished result sits at the end of the chain while the output
// register still holds an untaken beat. Angles are degrees times
// 2^ANGLE_FRAC_BITS, rounded half away from zero, in -90..+90; an all
// zero sample gives zero angles with both undefined flags set.
module accel_tilt_roll_pitch #(
   parameter int SAMPLE_WIDTH    = 16,
   parameter int ANGLE_FRAC_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // x_raw, y_raw, z_raw
   input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]   req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // roll_angle, pitch_angle
   output logic [2*atrp_pkg::ANGLE_WIDTH-1:0]    rsp_tdata,
   // roll_undefined, pitch_undefined
   output logic [1:0]                            rsp_tuser
);
   import atrp_pkg::*;

   logic signed [SAMPLE_WIDTH-1:0] x_s, y_s, z_s;
   logic signed [SAMPLE_WIDTH:0]   roll_num, pitch_num;
   logic                           adv;
   logic [LANE_DEPTH-1:0]          valid_in, valid_ff;
   logic [ANGLE_WIDTH-1:0]         roll_a, pitch_a;
   logic                           roll_u, pitch_u;
   logic                           out_valid_in, out_valid_ff;
   logic [2*ANGLE_WIDTH-1:0]       out_data_ff;
   logic [1:0]                     out_user_ff;

   assign x_s = $signed(req_tdata[SAMPLE_WIDTH-1:0]);
   assign y_s = $signed(req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]);
   assign z_s = $signed(req_tdata[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH]);

   assign roll_num  = (SAMPLE_WIDTH+1)'(y_s);
   assign pitch_num = -((SAMPLE_WIDTH+1)'(x_s));

   // chain stalls only when its last beat cannot leave
   assign adv        = !(valid_ff[LANE_DEPTH-1] && out_valid_ff && !rsp_tready);
   assign req_tready = adv;

   assign valid_in = {valid_ff[LANE_DEPTH-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   atrp_lane #(
      .SAMPLE_WIDTH    (SAMPLE_WIDTH),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_roll (
      .clock   (clock),
      .en      (adv),
      .num_i   (roll_num),
      .p_i     (x_s),
      .q_i     (z_s),
      .angle_o (roll_a),
      .undef_o (roll_u)
   );

   atrp_lane #(
      .SAMPLE_WIDTH    (SAMPLE_WIDTH),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_pitch (
      .clock   (clock),
      .en      (adv),
      .num_i   (pitch_num),
      .p_i     (y_s),
      .q_i     (z_s),
      .angle_o (pitch_a),
      .undef_o (pitch_u)
   );

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      if (adv && valid_ff[LANE_DEPTH-1]) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && valid_ff[LANE_DEPTH-1]) begin
         out_data_ff <= {pitch_a, roll_a};
         out_user_ff <= {pitch_u, roll_u};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   // a stall means a waiting beat at the output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("chain stalled without a blocked output beat");

   // both flags come from the same all-zero sample
   a_flags_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[0] == rsp_tuser[1])
      else $error("undefined flags disagree");

   // an undefined angle is forced to zero
   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("undefined angle not zero");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

endmodule

FILE: tb/sv/tb_accel_tilt_roll_pitch.sv
// ----------------------------------------------------------------------------
// tb_accel_tilt_roll_pitch: testbench for the accelerometer tilt block
// Drives directed samples, then three-axis samples in random bursts, predicts
// roll and pitch with a local fixed-point square root and cordic, and checks
// every result beat in order while the result side stalls on its own pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_accel_tilt_roll_pitch;

   localparam int SW          = 16;
   localparam int FRAC        = 8;
   localparam int STEPS       = atrp_pkg::CORDIC_STEPS;
   localparam int QFRAC       = atrp_pkg::TAB_FRAC;
   localparam int N_RANDOM    = 1450;
   localparam int IDLE_LIMIT  = 20000;
   localparam int DRAIN_WAIT  = 80;

   typedef struct packed {
      logic signed [15:0] roll;
      logic signed [15:0] pitch;
      logic               roll_undef;
      logic               pitch_undef;
   } tilt_result_t;

   // arctangent of 2^-i in degrees, q24, worked out from series at startup
   longint angle_table [STEPS];

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n   -= res + bitv;
            res  = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned arctan_series(longint unsigned p0, longint unsigned d);
      longint unsigned p, sum, k;
      p = p0; sum = 0; k = 0;
      while (p != 0) begin
         if (k[0] == 1'b0) sum += p / (2 * k + 1);
         else sum -= p / (2 * k + 1);
         p /= d;
         k++;
      end
      return sum;
   endfunction

   task automatic fill_angle_table();
      longint unsigned one, qpi, r, n, ip, rem, frac;
      one = 64'd1 << 56;
      qpi = 4 * arctan_series(one / 5, 25) - arctan_series(one / 239, 57121);
      angle_table[0] = longint'(45) << QFRAC;
      for (int i = 1; i < STEPS; i++) begin
         r = arctan_series(one >> i, 64'd1 << (2 * i));
         n = r * 45;
         ip = n / qpi; rem = n % qpi; frac = 0;
         for (int b = 0; b < QFRAC; b++) begin
            rem <<= 1; frac <<= 1;
            if (rem >= qpi) begin
               rem -= qpi; frac |= 1;
            end
         end
         angle_table[i] = longint'((ip << QFRAC) | frac);
      end
   endtask

   // signed angle of atan(num / sqrt(p^2 + q^2)) in degrees * 2^FRAC
   function automatic longint tilt_angle(longint num, longint p, longint q, output bit undef);
      longint full, cx, cy, nx, ang, r;
      longint unsigned mag;
      int k;
      full  = longint'(90) << FRAC;
      k     = 31 - SW;
      undef = 0;
      mag   = longint'(p * p) + longint'(q * q);
      if (mag == 0) begin
         if (num == 0) begin
            undef = 1;
            return 0;
         end
         return num > 0 ? full : -full;
      end
      cx  = longint'(int_sqrt(mag << (2 * k)));
      cy  = (num < 0 ? -num : num) <<< k;
      ang = 0;
      for (int i = 0; i < STEPS; i++) begin
         if (cy >= 0) begin
            nx = cx + floor_shift(cy, i);
            cy = cy - floor_shift(cx, i);
            ang += angle_table[i];
         end else begin
            nx = cx - floor_shift(cy, i);
            cy = cy + floor_shift(cx, i);
            ang -= angle_table[i];
         end
         cx = nx;
      end
      r = floor_shift(ang + (longint'(1) << (QFRAC - FRAC - 1)), QFRAC - FRAC);
      if (r < 0) r = 0;
      if (r > full) r = full;
      return num < 0 ? -r : r;
   endfunction

   function automatic tilt_result_t predict_tilt(logic [47:0] sample);
      tilt_result_t res;
      longint x, y, z;
      bit ru, pu;
      x = longint'($signed(sample[15:0]));
      y = longint'($signed(sample[31:16]));
      z = longint'($signed(sample[47:32]));
      res.roll        = 16'(tilt_angle(y, x, z, ru));
      res.pitch       = 16'(tilt_angle(-x, y, z, pu));
      res.roll_undef  = ru;
      res.pitch_undef = pu;
      return res;
   endfunction

   class tilt_scoreboard;
      tilt_result_t pending_angles[$];
      int errors;

      function void note_sample(logic [47:0] sample);
         pending_angles.push_back(predict_tilt(sample));
      endfunction

      function void check_result(tilt_result_t got);
         tilt_result_t want;
         if (pending_angles.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, got);
            errors++;
            return;
         end
         want = pending_angles.pop_front();
         if (got.roll !== want.roll) begin
            $display("%0t: roll expected %0d actual %0d", $time, want.roll, got.roll);
            errors++;
         end
         if (got.pitch !== want.pitch) begin
            $display("%0t: pitch expected %0d actual %0d", $time, want.pitch, got.pitch);
            errors++;
         end
         if (got.roll_undef !== want.roll_undef) begin
            $display("%0t: roll_undefined expected %b actual %b", $time,
                     want.roll_undef, got.roll_undef);
            errors++;
         end
         if (got.pitch_undef !== want.pitch_undef) begin
            $display("%0t: pitch_undefined expected %b actual %b", $time,
                     want.pitch_undef, got.pitch_undef);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;     // x_raw, y_raw, z_raw
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // roll_angle, pitch_angle
   logic [1:0]  rsp_tuser;          // roll_undefined, pitch_undefined

   tilt_scoreboard sb = new();
   int  idle_cycles;
   bit  stimulus_done;

   always #1 clock = ~clock;

   accel_tilt_roll_pitch i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // monitor, stall pattern and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_sample(req_tdata);
         if (rsp_tvalid && rsp_tready)
            sb.check_result({rsp_tdata[15:0], rsp_tdata[31:16], rsp_tuser[0], rsp_tuser[1]});
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (stimulus_done && sb.pending_angles.size() == 0))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("accel_tilt_roll_pitch: mismatch");
            $finish;
         end
         // long stretches of ready, then of light stalling, then of heavy stalling
         case ((($time / 2) / 300) % 3)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z);
      req_tvalid <= 1'b1;
      req_tdata  <= {z, y, x};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic pause_sender(int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   function automatic logic [15:0] random_axis();
      case ($urandom_range(0, 5))
         0: return 16'($urandom_range(0, 6) - 3);
         1: return 16'($signed($urandom_range(0, 1024)) - 512);
         2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic signed [15:0] lo, hi;
      int burst;
      lo = 16'sh8000;
      hi = 16'sh7fff;
      stimulus_done = 0;
      idle_cycles   = 0;
      fill_angle_table();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all zero, single axes, extremes, ties of magnitude
      send_sample(0, 0, 0);
      send_sample(1, 0, 0);
      send_sample(-1, 0, 0);
      send_sample(0, 1, 0);
      send_sample(0, -1, 0);
      send_sample(0, 0, 1);
      send_sample(0, 0, -256);
      send_sample(lo, 0, 0);
      send_sample(hi, 0, 0);
      send_sample(0, lo, 0);
      send_sample(0, hi, 0);
      send_sample(lo, lo, lo);
      send_sample(hi, hi, hi);
      send_sample(lo, hi, lo);
      send_sample(hi, lo, hi);
      send_sample(256, 256, 256);
      send_sample(-256, 256, 0);
      send_sample(0, 0, lo);
      send_sample(1, 1, hi);
      send_sample(-1, -1, -1);
      send_sample(181, -181, 256);
      pause_sender(3);

      for (int n = 0; n < N_RANDOM; ) begin
         burst = $urandom_range(1, 40);
         for (int b = 0; b < burst && n < N_RANDOM; b++, n++)
            send_sample(random_axis(), random_axis(), random_axis());
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
      end
      req_tvalid <= 1'b0;
      stimulus_done = 1;

      while (sb.pending_angles.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.errors == 0)
         $display("accel_tilt_roll_pitch: match");
      else
         $display("accel_tilt_roll_pitch: mismatch");
      $finish;
   end

endmodule
